/* sv/wrcp_pkg.sv */
package wrcp_pkg;

    localparam int NUM_CELLS = 9;
    localparam int OCC_W     = 9;
    localparam int CELL_W    = 4;
    localparam int WEIGHT_W  = 31;
    localparam int AMOUNT_W  = 32;
    localparam int RND_W     = 31;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = $clog2(NUM_CELLS);
    localparam int TOTAL_W   = WEIGHT_W + $clog2(NUM_CELLS);
    localparam int BIT_CNT_W = $clog2(RND_W + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [WEIGHT_W-1:0] INIT_RESET = WEIGHT_W'(1000);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT   = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_ADJUST = 2'd2,
        ACT_PICK   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_IGNORED    = 2'd1,
        ST_NO_WEIGHTS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_ADJ,
        S_DIV,
        S_WALK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic start;
    } rem_ctrl_t;

    typedef struct packed {
        logic done;
    } rem_stat_t;

endpackage

/* sv/wrcp_rem_unit.sv */
module wrcp_rem_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wrcp_pkg::rem_ctrl_t              ctrl,
    input  logic [wrcp_pkg::RND_W-1:0]       dividend,
    input  logic [wrcp_pkg::TOTAL_W-1:0]     divisor,
    output wrcp_pkg::rem_stat_t              stat,
    output logic [wrcp_pkg::TOTAL_W-1:0]     remainder
);

    logic [wrcp_pkg::RND_W-1:0]     dvd_reg, dvd_next;
    logic [wrcp_pkg::TOTAL_W-1:0]   rem_reg, rem_next;
    logic [wrcp_pkg::BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [wrcp_pkg::TOTAL_W:0]     trial;
    logic [wrcp_pkg::TOTAL_W:0]     diff;
    logic                           fits;

    // one quotient bit per cycle, restoring form
    assign trial = {rem_reg, dvd_reg[wrcp_pkg::RND_W-1]};
    assign fits  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = wrcp_pkg::BIT_CNT_W'(wrcp_pkg::RND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[wrcp_pkg::RND_W-2:0], 1'b0};
            rem_next = fits ? diff[wrcp_pkg::TOTAL_W-1:0] : trial[wrcp_pkg::TOTAL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wrcp_pkg::BIT_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

/* sv/weighted_random_cell_picker.sv */
// channel   direction  payload                                       handshake
// s_axis    in         tuser action, tdata occ/cell/amount/random    tvalid/tready
// m_axis    out        tuser status, tdata chosen_cell               tvalid/tready
// cfg       in         initial_weight                                valid/ready
//
// init and load write the weights in SUM, then finish; adjust sums the weights
// (one cycle per cell), then updates the cell in ADJ; pick sums the weights, runs
// the bit-serial remainder unit (one bit per cycle), then one cycle per cell in the prefix walk
// reset clears all weights to zero and sets the initial weight to 1000
// a new item is taken while a finished result waits in the output register
module weighted_random_cell_picker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // occupied_cells, cell_req, amount, random_value, zero pad
    input  logic [79:0]                       s_axis_tdata,
    // action
    input  logic [wrcp_pkg::ACTION_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // chosen_cell, zero pad
    output logic [7:0]                        m_axis_tdata,
    // status
    output logic [wrcp_pkg::STATUS_W-1:0]     m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wrcp_pkg::WEIGHT_W-1:0]     cfg_data
);

    localparam int CELL_LO = wrcp_pkg::OCC_W;
    localparam int AMT_LO  = CELL_LO + wrcp_pkg::CELL_W;
    localparam int RND_LO  = AMT_LO + wrcp_pkg::AMOUNT_W;
    localparam int ADJ_W   = wrcp_pkg::WEIGHT_W + 3;
    localparam int CHK_W   = wrcp_pkg::TOTAL_W + 2;

    wrcp_pkg::state_t                state_reg, state_next;
    wrcp_pkg::action_t               action_reg, action_next;
    logic [wrcp_pkg::OCC_W-1:0]      occ_reg, occ_next;
    logic [wrcp_pkg::CELL_W-1:0]     cell_reg, cell_next;
    logic [wrcp_pkg::AMOUNT_W-1:0]   amount_reg, amount_next;
    logic [wrcp_pkg::RND_W-1:0]      random_reg, random_next;
    logic [wrcp_pkg::WEIGHT_W-1:0]   weights_reg [wrcp_pkg::NUM_CELLS];
    logic [wrcp_pkg::WEIGHT_W-1:0]   weights_next [wrcp_pkg::NUM_CELLS];
    logic [wrcp_pkg::WEIGHT_W-1:0]   init_weight_reg;
    logic [wrcp_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [wrcp_pkg::TOTAL_W-1:0]    run_reg, run_next;
    logic [wrcp_pkg::IDX_W-1:0]      cnt_reg, cnt_next;
    logic                            div_start_reg, div_start_next;
    logic [wrcp_pkg::CELL_W-1:0]     res_cell_reg, res_cell_next;
    wrcp_pkg::status_t               res_status_reg, res_status_next;
    logic                            m_valid_reg, m_valid_next;
    logic [wrcp_pkg::CELL_W-1:0]     out_cell_reg, out_cell_next;
    wrcp_pkg::status_t               out_status_reg, out_status_next;

    logic                            in_fire;
    logic                            cell_ok;
    logic [wrcp_pkg::IDX_W-1:0]      cell_idx;
    logic [wrcp_pkg::WEIGHT_W-1:0]   w_sel;
    logic [wrcp_pkg::WEIGHT_W-1:0]   w_cnt;
    logic signed [ADJ_W-1:0]         adj_sum;
    logic signed [CHK_W-1:0]         tot_chk;
    logic [wrcp_pkg::WEIGHT_W-1:0]   adj_weight;
    logic                            adj_ignore;
    logic [wrcp_pkg::TOTAL_W-1:0]    run_sum;
    logic                            last_cell;
    wrcp_pkg::rem_ctrl_t             rem_ctrl;
    wrcp_pkg::rem_stat_t             rem_stat;
    logic [wrcp_pkg::TOTAL_W-1:0]    rem_val;

    wrcp_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rem_ctrl),
        .dividend  (random_reg),
        .divisor   (total_reg),
        .stat      (rem_stat),
        .remainder (rem_val)
    );

    assign rem_ctrl.start = div_start_reg;

    assign s_axis_tready = (state_reg == wrcp_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign cell_ok  = (cell_reg != '0) &&
                      ({1'b0, cell_reg} <= (wrcp_pkg::CELL_W + 1)'(wrcp_pkg::NUM_CELLS));
    assign cell_idx = wrcp_pkg::IDX_W'(cell_reg - 1'b1);
    assign w_sel    = weights_reg[cell_idx];
    assign w_cnt    = weights_reg[cnt_reg];
    assign last_cell = (cnt_reg == wrcp_pkg::IDX_W'(wrcp_pkg::NUM_CELLS - 1));

    assign adj_sum = signed'({3'b000, w_sel}) +
                     signed'({{(ADJ_W - wrcp_pkg::AMOUNT_W){amount_reg[wrcp_pkg::AMOUNT_W-1]}},
                              amount_reg});
    assign tot_chk = signed'({2'b00, total_reg}) +
                     signed'({{(CHK_W - wrcp_pkg::AMOUNT_W){amount_reg[wrcp_pkg::AMOUNT_W-1]}},
                              amount_reg});
    assign adj_ignore = (!amount_reg[wrcp_pkg::AMOUNT_W-1] && (amount_reg != '0) &&
                         (w_sel == wrcp_pkg::WEIGHT_MAX)) || (tot_chk <= 0);

    always_comb
    begin
        if (adj_sum < 0)
            adj_weight = '0;
        else if (adj_sum > signed'({3'b000, wrcp_pkg::WEIGHT_MAX}))
            adj_weight = wrcp_pkg::WEIGHT_MAX;
        else
            adj_weight = adj_sum[wrcp_pkg::WEIGHT_W-1:0];
    end

    assign run_sum = run_reg + wrcp_pkg::TOTAL_W'(w_cnt);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        occ_next        = occ_reg;
        cell_next       = cell_reg;
        amount_next     = amount_reg;
        random_next     = random_reg;
        weights_next    = weights_reg;
        total_next      = total_reg;
        run_next        = run_reg;
        cnt_next        = cnt_reg;
        div_start_next  = 1'b0;
        res_cell_next   = res_cell_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_cell_next   = out_cell_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            wrcp_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    action_next     = wrcp_pkg::action_t'(s_axis_tuser);
                    occ_next        = s_axis_tdata[wrcp_pkg::OCC_W-1:0];
                    cell_next       = s_axis_tdata[AMT_LO-1:CELL_LO];
                    amount_next     = s_axis_tdata[RND_LO-1:AMT_LO];
                    random_next     = s_axis_tdata[RND_LO+wrcp_pkg::RND_W-1:RND_LO];
                    total_next      = '0;
                    run_next        = '0;
                    cnt_next        = '0;
                    res_cell_next   = '0;
                    res_status_next = wrcp_pkg::ST_DONE;
                    state_next      = wrcp_pkg::S_SUM;
                end
            end
            wrcp_pkg::S_SUM:
            begin
                unique case (action_reg)
                    wrcp_pkg::ACT_INIT:
                    begin
                        for (int k = 0; k < wrcp_pkg::NUM_CELLS; k++)
                        begin
                            if (k < wrcp_pkg::OCC_W && occ_reg[k % wrcp_pkg::OCC_W])
                                weights_next[k] = '0;
                            else
                                weights_next[k] = init_weight_reg;
                        end
                        state_next = wrcp_pkg::S_FINISH;
                    end
                    wrcp_pkg::ACT_LOAD:
                    begin
                        if (!cell_ok)
                            res_status_next = wrcp_pkg::ST_IGNORED;
                        else if (amount_reg[wrcp_pkg::AMOUNT_W-1])
                            weights_next[cell_idx] = '0;
                        else
                            weights_next[cell_idx] = amount_reg[wrcp_pkg::WEIGHT_W-1:0];
                        state_next = wrcp_pkg::S_FINISH;
                    end
                    default:
                    begin
                        if (action_reg == wrcp_pkg::ACT_ADJUST && !cell_ok)
                        begin
                            res_status_next = wrcp_pkg::ST_IGNORED;
                            state_next      = wrcp_pkg::S_FINISH;
                        end
                        else
                        begin
                            total_next = total_reg + wrcp_pkg::TOTAL_W'(w_cnt);
                            cnt_next   = cnt_reg + 1'b1;
                            if (last_cell)
                            begin
                                cnt_next = '0;
                                if (action_reg == wrcp_pkg::ACT_ADJUST)
                                    state_next = wrcp_pkg::S_ADJ;
                                else if (total_next == '0)
                                begin
                                    res_status_next = wrcp_pkg::ST_NO_WEIGHTS;
                                    state_next      = wrcp_pkg::S_FINISH;
                                end
                                else
                                begin
                                    div_start_next = 1'b1;
                                    state_next     = wrcp_pkg::S_DIV;
                                end
                            end
                        end
                    end
                endcase
            end
            wrcp_pkg::S_ADJ:
            begin
                if (adj_ignore)
                    res_status_next = wrcp_pkg::ST_IGNORED;
                else
                    weights_next[cell_idx] = adj_weight;
                state_next = wrcp_pkg::S_FINISH;
            end
            wrcp_pkg::S_DIV:
            begin
                if (rem_stat.done)
                    state_next = wrcp_pkg::S_WALK;
            end
            wrcp_pkg::S_WALK:
            begin
                // target = rem + 1, so target <= run means rem < run
                run_next = run_sum;
                cnt_next = cnt_reg + 1'b1;
                if (rem_val < run_sum || last_cell)
                begin
                    res_cell_next = wrcp_pkg::CELL_W'(cnt_reg) + 1'b1;
                    state_next    = wrcp_pkg::S_FINISH;
                end
            end
            wrcp_pkg::S_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_cell_next   = res_cell_reg;
                    out_status_next = res_status_reg;
                    state_next      = wrcp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wrcp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= wrcp_pkg::S_IDLE;
            div_start_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            init_weight_reg <= wrcp_pkg::INIT_RESET;
            for (int k = 0; k < wrcp_pkg::NUM_CELLS; k++)
            begin
                weights_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
            weights_reg   <= weights_next;
            if (cfg_valid && cfg_ready)
                init_weight_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        occ_reg        <= occ_next;
        cell_reg       <= cell_next;
        amount_reg     <= amount_next;
        random_reg     <= random_next;
        total_reg      <= total_next;
        run_reg        <= run_next;
        cnt_reg        <= cnt_next;
        res_cell_reg   <= res_cell_next;
        res_status_reg <= res_status_next;
        out_cell_reg   <= out_cell_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(8 - wrcp_pkg::CELL_W){1'b0}}, out_cell_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule
